@@ design/scba_pkg.sv @@
`default_nettype none

package scba_pkg;

    // The pool layout assumes MIN_SLOT_BYTES is a power of two.
    localparam int NUM_CLASSES     = 13;
    localparam int MIN_SLOT_BYTES  = 64;
    localparam int WORDS_PER_CLASS = 8;

    localparam int MIN_SLOT_LOG2 = $clog2(MIN_SLOT_BYTES);
    localparam int MAP_DEPTH     = NUM_CLASSES * WORDS_PER_CLASS;
    localparam int MAP_IDX_W     = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
    localparam int CLASS_W       = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int WORD_IDX_W    = (WORDS_PER_CLASS > 1) ? $clog2(WORDS_PER_CLASS) : 1;
    localparam int WORD_CNT_W    = $clog2(WORDS_PER_CLASS + 1);
    localparam int SLOT_W        = WORD_IDX_W + 6;
    localparam int SHIFT_W       = 7;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_REFUSED = 2'd1;
    localparam logic [1:0] ST_OUTSIDE = 2'd2;

    typedef logic [63:0] addr_t;
    typedef addr_t class_tab_t [NUM_CLASSES];

    typedef struct packed {
        logic        command;
        logic [31:0] request_size;
        logic [63:0] free_address;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] slot_address;
    } resp_t;

    typedef struct packed {
        logic                 en;
        logic [MAP_IDX_W-1:0] idx;
    } map_rd_t;

    typedef struct packed {
        logic                 en;
        logic [MAP_IDX_W-1:0] idx;
        logic [63:0]          word;
    } map_wr_t;

    function automatic class_tab_t class_bytes_tab();
        class_tab_t t;
        for (int k = 0; k < NUM_CLASSES; k++)
            t[k] = addr_t'(MIN_SLOT_BYTES) << k;
        return t;
    endfunction

    function automatic class_tab_t class_start_tab();
        class_tab_t t;
        addr_t      off;
        off = '0;
        for (int k = 0; k < NUM_CLASSES; k++)
        begin
            t[k] = off;
            off  = off + (addr_t'(MIN_SLOT_BYTES) << k) * addr_t'(WORDS_PER_CLASS * 64);
        end
        return t;
    endfunction

    function automatic class_tab_t class_end_tab();
        class_tab_t t;
        addr_t      off;
        off = '0;
        for (int k = 0; k < NUM_CLASSES; k++)
        begin
            off  = off + (addr_t'(MIN_SLOT_BYTES) << k) * addr_t'(WORDS_PER_CLASS * 64);
            t[k] = off;
        end
        return t;
    endfunction

    localparam class_tab_t CLASS_BYTES = class_bytes_tab();
    localparam class_tab_t CLASS_START = class_start_tab();
    localparam class_tab_t CLASS_END   = class_end_tab();

    // Word w of class c sits at c * WORDS_PER_CLASS + w.
    function automatic logic [MAP_IDX_W-1:0] map_index(logic [CLASS_W-1:0]    cls,
                                                      logic [WORD_IDX_W-1:0] w);
        return MAP_IDX_W'(cls) * MAP_IDX_W'(WORDS_PER_CLASS) + MAP_IDX_W'(w);
    endfunction

endpackage

`default_nettype wire

@@ design/scba_map.sv @@
`default_nettype none

module scba_map (
    input  logic              clk,
    input  logic              rst_n,
    input  scba_pkg::map_rd_t rd,
    input  scba_pkg::map_wr_t wr,
    output logic [63:0]       rd_word
);
    import scba_pkg::*;

    logic [63:0]          mem [MAP_DEPTH];
    logic [MAP_DEPTH-1:0] valid_reg;
    logic                 rd_valid_reg;
    logic [63:0]          rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.idx] <= wr.word;
        end
        if (rd.en)
        begin
            rd_data_reg <= mem[rd.idx];
        end
    end

    // A word never written reads as all zeros, as reset clears its valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.idx] <= 1'b1;
            end
            if (rd.en)
            begin
                rd_valid_reg <= valid_reg[rd.idx];
            end
        end
    end

    assign rd_word = rd_valid_reg ? rd_data_reg : 64'd0;

endmodule

`default_nettype wire

@@ design/size_class_bitmap_allocator.sv @@
`default_nettype none

// Slab allocator over one pool of power-of-two size classes, one request at a time.
// A successful allocate request scans from 1 to WORDS_PER_CLASS used-bit words in its
// class, as the bitmap memory is read one word per cycle with a registered read; an
// allocate refused because its class is full scans all WORDS_PER_CLASS words. A free
// request inside the pool compares the pool offset against 1 to NUM_CLASSES classes, one
// 64-bit compare per cycle, and a free outside the pool compares against all NUM_CLASSES.
// An allocate that is too large for every class goes straight to the result. The result
// waits in an output register, a stalled result holds the sequencer in its last state,
// and the next request is taken as soon as the sequencer is back at idle. The bitmap needs
// no clearing pass after reset. pool_base may be written whenever the block is idle.

module size_class_bitmap_allocator (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  scba_pkg::req_t  in_data,
    output logic            out_valid,
    input  logic            out_stall,
    output scba_pkg::resp_t out_data,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [63:0]     cfg_data
);
    import scba_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_AREAD   = 8'b0000_0010,
        S_ACHECK  = 8'b0000_0100,
        S_ADDR    = 8'b0000_1000,
        S_FSEARCH = 8'b0001_0000,
        S_FSLOT   = 8'b0010_0000,
        S_FREAD   = 8'b0100_0000,
        S_FINISH  = 8'b1000_0000
    } state_t;

    state_t                state_reg, state_next;
    logic [63:0]           pool_base_reg, pool_base_next;
    logic                  out_valid_reg, out_valid_next;
    resp_t                 out_data_reg, out_data_next;
    logic [CLASS_W-1:0]    class_reg, class_next;
    logic [WORD_CNT_W-1:0] w_reg, w_next;
    logic [WORD_IDX_W-1:0] cur_w_reg, cur_w_next;
    logic [63:0]           acc_reg, acc_next;
    logic [63:0]           slot_off_reg, slot_off_next;
    logic [SLOT_W-1:0]     slot_reg, slot_next;
    logic [1:0]            status_reg, status_next;
    logic [63:0]           result_reg, result_next;
    logic                  toggle_reg, toggle_next;

    map_rd_t               map_rd;
    map_wr_t               map_wr;
    logic [63:0]           rd_word;

    logic [CLASS_W-1:0]    size_class;
    logic                  size_fits;
    logic [63:0]           clear_mask;
    logic                  word_open;
    logic [5:0]            bit_idx;
    logic [SHIFT_W-1:0]    shamt;
    logic [63:0]           class_delta;
    logic [63:0]           slot_shifted;
    logic [MAP_IDX_W-1:0]  free_idx;

    scba_map u_map (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd      (map_rd),
        .wr      (map_wr),
        .rd_word (rd_word)
    );

    // Smallest class whose slot holds the requested size.
    always_comb
    begin
        size_class = '0;
        size_fits  = 1'b0;
        for (int k = NUM_CLASSES - 1; k >= 0; k--)
        begin
            if (64'(in_data.request_size) <= CLASS_BYTES[k])
            begin
                size_fits  = 1'b1;
                size_class = CLASS_W'(k);
            end
        end
    end

    // Lowest clear bit of the word under test, as a one-hot mask and as an index.
    always_comb
    begin
        clear_mask = ~rd_word & (rd_word + 64'd1);
        word_open  = (rd_word != '1);
        bit_idx    = '0;
        for (int b = 63; b >= 0; b--)
        begin
            if (clear_mask[b])
            begin
                bit_idx = 6'(b);
            end
        end
    end

    assign shamt        = SHIFT_W'(MIN_SLOT_LOG2) + SHIFT_W'(class_reg);
    assign class_delta  = acc_reg - CLASS_START[class_reg];
    assign slot_shifted = class_delta >> shamt;
    assign free_idx     = map_index(class_reg, slot_reg[SLOT_W-1:6]);

    always_comb
    begin
        map_rd.en  = (state_reg == S_AREAD) || (state_reg == S_FREAD)
                     || ((state_reg == S_ACHECK) && (w_reg != WORD_CNT_W'(WORDS_PER_CLASS)));
        map_rd.idx = (state_reg == S_FREAD) ? free_idx
                     : map_index(class_reg, w_reg[WORD_IDX_W-1:0]);

        map_wr.en   = ((state_reg == S_ACHECK) && word_open) || toggle_reg;
        map_wr.idx  = toggle_reg ? free_idx : map_index(class_reg, cur_w_reg);
        map_wr.word = toggle_reg ? (rd_word ^ (64'd1 << slot_reg[5:0]))
                      : (rd_word | clear_mask);
    end

    always_comb
    begin
        state_next     = state_reg;
        class_next     = class_reg;
        w_next         = w_reg;
        cur_w_next     = cur_w_reg;
        acc_next       = acc_reg;
        slot_off_next  = slot_off_reg;
        slot_next      = slot_reg;
        status_next    = status_reg;
        result_next    = result_reg;
        toggle_next    = 1'b0;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_data.command == CMD_FREE)
                    begin
                        acc_next   = in_data.free_address - pool_base_reg;
                        class_next = '0;
                        state_next = S_FSEARCH;
                    end
                    else if (size_fits)
                    begin
                        class_next = size_class;
                        w_next     = '0;
                        state_next = S_AREAD;
                    end
                    else
                    begin
                        status_next = ST_REFUSED;
                        result_next = '0;
                        state_next  = S_FINISH;
                    end
                end
            end
            S_AREAD:
            begin
                acc_next   = pool_base_reg + CLASS_START[class_reg];
                cur_w_next = w_reg[WORD_IDX_W-1:0];
                w_next     = w_reg + WORD_CNT_W'(1);
                state_next = S_ACHECK;
            end
            S_ACHECK:
            begin
                // The next word is already being read while this one is tested.
                if (word_open)
                begin
                    slot_off_next = 64'({cur_w_reg, bit_idx}) << shamt;
                    state_next    = S_ADDR;
                end
                else if (cur_w_reg == WORD_IDX_W'(WORDS_PER_CLASS - 1))
                begin
                    status_next = ST_REFUSED;
                    result_next = '0;
                    state_next  = S_FINISH;
                end
                else
                begin
                    cur_w_next = w_reg[WORD_IDX_W-1:0];
                    w_next     = w_reg + WORD_CNT_W'(1);
                end
            end
            S_ADDR:
            begin
                status_next = ST_DONE;
                result_next = acc_reg + slot_off_reg;
                state_next  = S_FINISH;
            end
            S_FSEARCH:
            begin
                if (acc_reg < CLASS_END[class_reg])
                begin
                    state_next = S_FSLOT;
                end
                else if (class_reg == CLASS_W'(NUM_CLASSES - 1))
                begin
                    status_next = ST_OUTSIDE;
                    result_next = '0;
                    state_next  = S_FINISH;
                end
                else
                begin
                    class_next = class_reg + CLASS_W'(1);
                end
            end
            S_FSLOT:
            begin
                slot_next  = slot_shifted[SLOT_W-1:0];
                state_next = S_FREAD;
            end
            S_FREAD:
            begin
                // The toggled word is written back in the cycle after the read.
                toggle_next = 1'b1;
                status_next = ST_DONE;
                result_next = '0;
                state_next  = S_FINISH;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next             = 1'b1;
                    out_data_next.status       = status_reg;
                    out_data_next.slot_address = result_reg;
                    state_next                 = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign pool_base_next = cfg_valid ? cfg_data : pool_base_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pool_base_reg <= '0;
            out_valid_reg <= 1'b0;
            toggle_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pool_base_reg <= pool_base_next;
            out_valid_reg <= out_valid_next;
            toggle_reg    <= toggle_next;
        end
    end

    always_ff @(posedge clk)
    begin
        class_reg    <= class_next;
        w_reg        <= w_next;
        cur_w_reg    <= cur_w_next;
        acc_reg      <= acc_next;
        slot_off_reg <= slot_off_next;
        slot_reg     <= slot_next;
        status_reg   <= status_next;
        result_reg   <= result_next;
        out_data_reg <= out_data_next;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign cfg_ready = 1'b1;

endmodule

`default_nettype wire
